FILE: hw/rtl/vgd_pkg.sv
`default_nettype none

package vgd_pkg;

  localparam int unsigned CharW     = 8;
  localparam int unsigned ShiftW    = 5;
  localparam int unsigned NumFields = 10;
  localparam int unsigned KeyLenW   = 4;
  localparam int unsigned KeyW      = NumFields * ShiftW;
  localparam int unsigned PosW      = 4;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned MaxKeyLen = 10;

  localparam logic [CfgIdxW-1:0] RegKeyLength = 2'd0;
  localparam logic [CfgIdxW-1:0] RegKeyShifts = 2'd1;

  localparam logic [ShiftW-1:0] MaxShift  = 5'd25;
  localparam logic [CharW-1:0]  UpperLo   = 8'd65;
  localparam logic [CharW-1:0]  UpperHi   = 8'd90;
  localparam logic [CharW-1:0]  LowerLo   = 8'd97;
  localparam logic [CharW-1:0]  LowerHi   = 8'd122;
  localparam logic [CharW-1:0]  DigitLo   = 8'd48;
  localparam logic [CharW-1:0]  DigitHi   = 8'd57;
  localparam logic [CharW-1:0]  AlphaSpan = 8'd26;
  localparam logic [CharW-1:0]  DigitSpan = 8'd10;

endpackage

`default_nettype wire

FILE: hw/rtl/vgd_if.sv
`default_nettype none

interface vgd_in_if;
  import vgd_pkg::*;
  logic             valid;
  logic             ready;
  logic [CharW-1:0] in_char;
  logic             message_start;

  modport source (output valid, output in_char, output message_start, input ready);
  modport sink (input valid, input in_char, input message_start, output ready);
endinterface

interface vgd_out_if;
  import vgd_pkg::*;
  logic             valid;
  logic             ready;
  logic [CharW-1:0] out_char;

  modport source (output valid, output out_char, input ready);
  modport sink (input valid, input out_char, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/vgd_key_ctrl.sv
`default_nettype none

module vgd_key_ctrl import vgd_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [KeyW-1:0]    cfg_wdata_i,
  input  wire logic               fire_i,
  input  wire logic               msg_start_i,
  output logic      [ShiftW-1:0]  shift_o
);

  logic [KeyLenW-1:0] len_q;
  logic [KeyW-1:0]    key_q;
  logic [PosW-1:0]    pos_q, pos_d;
  logic [PosW-1:0]    pos_cur;
  logic [KeyLenW-1:0] eff_len;
  logic [ShiftW-1:0]  raw_shift;
  logic [PosW:0]      pos_inc;

  always_comb begin
    if (len_q == '0) begin
      eff_len = KeyLenW'(1);
    end else if (len_q > KeyLenW'(MaxKeyLen)) begin
      eff_len = KeyLenW'(MaxKeyLen);
    end else begin
      eff_len = len_q;
    end
  end

  assign pos_cur = msg_start_i ? '0 : pos_q;

  always_comb begin
    raw_shift = '0;
    for (int k = 0; k < NumFields; k++) begin
      if (pos_cur == PosW'(k)) begin
        raw_shift = key_q[k*ShiftW +: ShiftW];
      end
    end
  end

  assign shift_o = (raw_shift > MaxShift) ? MaxShift : raw_shift;

  assign pos_inc = {1'b0, pos_cur} + (PosW+1)'(1);
  assign pos_d   = (pos_inc >= (PosW+1)'(eff_len)) ? '0 : pos_inc[PosW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= KeyLenW'(1);
      key_q <= '0;
      pos_q <= '0;
    end else begin
      if (cfg_we_i && (cfg_idx_i == RegKeyLength)) begin
        len_q <= cfg_wdata_i[KeyLenW-1:0];
      end
      if (cfg_we_i && (cfg_idx_i == RegKeyShifts)) begin
        key_q <= cfg_wdata_i;
      end
      if (fire_i) begin
        pos_q <= pos_d;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/vgd_datapath.sv
`default_nettype none

module vgd_datapath import vgd_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [CharW-1:0]  in_char_i,
  input  wire logic [ShiftW-1:0] shift_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic      [CharW-1:0]  out_char_o
);

  logic              s1_valid_q;
  logic [CharW-1:0]  s1_char_q;
  logic [ShiftW-1:0] s1_shift_q;
  logic              out_valid_q;
  logic [CharW-1:0]  out_char_q, out_char_d;
  logic              out_load, s1_load;

  logic              is_upper, is_lower, is_digit;
  logic [CharW-1:0]  base, span, off, sh;
  logic [ShiftW-1:0] dsh;

  assign out_load   = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || out_load;
  assign s1_load    = in_valid_i && in_ready_o;

  assign is_upper = (s1_char_q >= UpperLo) && (s1_char_q <= UpperHi);
  assign is_lower = (s1_char_q >= LowerLo) && (s1_char_q <= LowerHi);
  assign is_digit = (s1_char_q >= DigitLo) && (s1_char_q <= DigitHi);

  // digit shift folded into 0..10
  always_comb begin
    if (s1_shift_q > ShiftW'(20)) begin
      dsh = s1_shift_q - ShiftW'(20);
    end else if (s1_shift_q > ShiftW'(10)) begin
      dsh = s1_shift_q - ShiftW'(10);
    end else begin
      dsh = s1_shift_q;
    end
  end

  always_comb begin
    if (is_upper) begin
      base = UpperLo;
      span = AlphaSpan;
      sh   = CharW'(s1_shift_q);
    end else if (is_lower) begin
      base = LowerLo;
      span = AlphaSpan;
      sh   = CharW'(s1_shift_q);
    end else begin
      base = DigitLo;
      span = DigitSpan;
      sh   = CharW'(dsh);
    end
    off = s1_char_q - base;
    if (!(is_upper || is_lower || is_digit)) begin
      out_char_d = s1_char_q;
    end else if (off < sh) begin
      out_char_d = base + off + span - sh;
    end else begin
      out_char_d = base + off - sh;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (out_load) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_char_q  <= in_char_i;
      s1_shift_q <= shift_i;
    end
    if (out_load && s1_valid_q) begin
      out_char_q <= out_char_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;

endmodule

`default_nettype wire

FILE: hw/rtl/vigenere_decipher_core.sv
// an accepted input is registered in the input stage, then in the result stage
// throughput: one transaction per cycle, limited only by output back-pressure
// the key shift is picked at acceptance, the letter/digit subtract runs between
// the input register and the result register
// reset: key length 1, all shifts 0, key position 0, both stages empty
`default_nettype none

module vigenere_decipher_core import vgd_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [KeyW-1:0]    cfg_wdata_i,
  vgd_in_if.sink                  in_i,
  vgd_out_if.source               out_o
);

  logic              in_fire;
  logic [ShiftW-1:0] shift;

  assign in_fire = in_i.valid && in_i.ready;

  vgd_key_ctrl u_key_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .fire_i      (in_fire),
    .msg_start_i (in_i.message_start),
    .shift_o     (shift)
  );

  vgd_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .in_char_i   (in_i.in_char),
    .shift_i     (shift),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_char_o  (out_o.out_char)
  );

endmodule

`default_nettype wire
